// ===== rtl/c_like_lexer_assert.svh =====
// Assertion macros for the lexer RTL.
`ifndef C_LIKE_LEXER_ASSERT_SVH
`define C_LIKE_LEXER_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define CLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define CLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cll_pkg.sv =====
// Package with token types, character codes and shared structs of the lexer.
`default_nettype none

package cll_pkg;

  localparam logic [3:0] TOK_END      = 4'd0;
  localparam logic [3:0] TOK_LPAREN   = 4'd1;
  localparam logic [3:0] TOK_RPAREN   = 4'd2;
  localparam logic [3:0] TOK_COLON    = 4'd3;
  localparam logic [3:0] TOK_SEMI     = 4'd4;
  localparam logic [3:0] TOK_STAR     = 4'd5;
  localparam logic [3:0] TOK_LBRACKET = 4'd6;
  localparam logic [3:0] TOK_RBRACKET = 4'd7;
  localparam logic [3:0] TOK_LBRACE   = 4'd8;
  localparam logic [3:0] TOK_RBRACE   = 4'd9;
  localparam logic [3:0] TOK_STRING   = 4'd10;
  localparam logic [3:0] TOK_IDENT    = 4'd11;
  localparam logic [3:0] TOK_UNKNOWN  = 4'd12;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_UNDERLINE = 8'h5F;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic [3:0] punct_type(input logic [7:0] c);
    logic [3:0] t;
    case (c)
      8'h28:   t = TOK_LPAREN;
      8'h29:   t = TOK_RPAREN;
      8'h3A:   t = TOK_COLON;
      8'h3B:   t = TOK_SEMI;
      CH_STAR: t = TOK_STAR;
      8'h5B:   t = TOK_LBRACKET;
      8'h5D:   t = TOK_RBRACKET;
      8'h7B:   t = TOK_LBRACE;
      8'h7D:   t = TOK_RBRACE;
      default: t = TOK_UNKNOWN;
    endcase
    return t;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cll_front.sv =====
// Front end of the lexer: scanner state machine that classifies each byte into tokens.
`default_nettype none

module cll_front #(
  parameter int unsigned MAX_TEXT_BYTES = 65536
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_stall,
  input  wire logic [7:0]    in_text_byte,
  output cll_pkg::push_t     push_o
);
  import cll_pkg::*;

  localparam int unsigned PW = $clog2(MAX_TEXT_BYTES);
  localparam logic [PW-1:0] POS_LAST = PW'(MAX_TEXT_BYTES - 1);

  typedef enum logic [7:0] {
    M_IDLE       = 8'b0000_0001,
    M_SLASH      = 8'b0000_0010,
    M_LINE       = 8'b0000_0100,
    M_BLOCK      = 8'b0000_1000,
    M_BLOCK_STAR = 8'b0001_0000,
    M_STRING     = 8'b0010_0000,
    M_STRING_ESC = 8'b0100_0000,
    M_IDENT      = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic        emit;
    token_t      tok;
    logic        ld_start;
    logic [15:0] start;
    logic        ld_len;
    logic [15:0] len;
  } idle_res_t;

  function automatic idle_res_t idle_lex(input logic [7:0] c, input logic [15:0] pos,
                                         input logic [15:0] pos_inc);
    idle_res_t r;
    r.mode     = M_IDLE;
    r.emit     = 1'b0;
    r.tok      = '{kind: punct_type(c), start: pos, length: 16'd1, last: 1'b1};
    r.ld_start = 1'b0;
    r.start    = pos;
    r.ld_len   = 1'b0;
    r.len      = 16'd0;
    if (is_space(c)) begin
      r.emit = 1'b0;
    end else if (c == CH_NUL) begin
      r.emit     = 1'b1;
      r.tok.kind = TOK_END;
    end else if (c == CH_SLASH) begin
      r.mode     = M_SLASH;
      r.ld_start = 1'b1;
    end else if (c == CH_QUOTE) begin
      r.mode     = M_STRING;
      r.ld_start = 1'b1;
      r.start    = pos_inc;
      r.ld_len   = 1'b1;
    end else if (is_alpha(c)) begin
      r.mode     = M_IDENT;
      r.ld_start = 1'b1;
      r.ld_len   = 1'b1;
      r.len      = 16'd1;
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  mode_t            mode_r, mode_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [15:0]      pstart_r, pstart_nxt;
  logic [15:0]      plen_r, plen_nxt;
  logic [PW-1:0]    pos_inc;
  logic [PW+15:0]   pos_ext, pos_inc_ext;
  logic [15:0]      pos16, pos_inc16, plen_sat;
  logic             accept, pre_emit, run_idle, idle_emit;
  token_t           pre_tok;
  idle_res_t        ir;

  assign accept      = in_valid && !in_stall;
  assign pos_inc     = (pos_r == POS_LAST) ? '0 : pos_r + PW'(1);
  assign pos_ext     = {16'd0, pos_r};
  assign pos_inc_ext = {16'd0, pos_inc};
  assign pos16       = pos_ext[15:0];
  assign pos_inc16   = pos_inc_ext[15:0];
  assign plen_sat    = (plen_r == LEN_MAX) ? LEN_MAX : plen_r + 16'd1;
  assign ir          = idle_lex(in_text_byte, pos16, pos_inc16);

  always_comb begin
    mode_nxt   = mode_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    pre_emit   = 1'b0;
    run_idle   = 1'b0;
    pre_tok    = '{kind: TOK_STRING, start: pstart_r, length: plen_r, last: 1'b0};
    case (mode_r)
      M_SLASH: begin
        if (in_text_byte == CH_SLASH) begin
          mode_nxt = M_LINE;
        end else if (in_text_byte == CH_STAR) begin
          mode_nxt = M_BLOCK;
        end else begin
          pre_emit       = 1'b1;
          pre_tok.kind   = TOK_UNKNOWN;
          pre_tok.length = 16'd1;
          run_idle       = 1'b1;
        end
      end
      M_LINE: begin
        if (in_text_byte == CH_NUL) begin
          run_idle = 1'b1;
        end else if (in_text_byte == CH_LF || in_text_byte == CH_CR) begin
          mode_nxt = M_IDLE;
        end
      end
      M_BLOCK, M_BLOCK_STAR: begin
        if (in_text_byte == CH_NUL) begin
          run_idle = 1'b1;
        end else if (mode_r == M_BLOCK_STAR && in_text_byte == CH_SLASH) begin
          mode_nxt = M_IDLE;
        end else begin
          mode_nxt = (in_text_byte == CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
        end
      end
      M_STRING: begin
        if (in_text_byte == CH_NUL) begin
          pre_emit = 1'b1;
          run_idle = 1'b1;
        end else if (in_text_byte == CH_QUOTE) begin
          pre_emit = 1'b1;
          mode_nxt = M_IDLE;
        end else begin
          plen_nxt = plen_sat;
          if (in_text_byte == CH_BACKSLASH) begin
            mode_nxt = M_STRING_ESC;
          end
        end
      end
      M_STRING_ESC: begin
        if (in_text_byte == CH_NUL) begin
          pre_emit = 1'b1;
          run_idle = 1'b1;
        end else begin
          plen_nxt = plen_sat;
          mode_nxt = M_STRING;
        end
      end
      M_IDENT: begin
        if (is_alpha(in_text_byte) || is_digit(in_text_byte) ||
            in_text_byte == CH_UNDERLINE) begin
          plen_nxt = plen_sat;
        end else begin
          pre_emit     = 1'b1;
          pre_tok.kind = TOK_IDENT;
          run_idle     = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase
    if (run_idle) begin
      mode_nxt = ir.mode;
      if (ir.ld_start) begin
        pstart_nxt = ir.start;
      end
      if (ir.ld_len) begin
        plen_nxt = ir.len;
      end
    end
    if (in_text_byte == CH_NUL) begin
      mode_nxt   = M_IDLE;
      pos_nxt    = '0;
      pstart_nxt = 16'd0;
      plen_nxt   = 16'd0;
    end else begin
      pos_nxt = pos_inc;
    end
  end

  assign idle_emit = run_idle && ir.emit;

  always_comb begin
    push_o.cnt       = accept ? ({1'b0, pre_emit} + {1'b0, idle_emit}) : 2'd0;
    push_o.tok0      = pre_emit ? pre_tok : ir.tok;
    push_o.tok0.last = !(pre_emit && idle_emit);
    push_o.tok1      = ir.tok;
    push_o.tok1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      pstart_r <= 16'd0;
      plen_r   <= 16'd0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cll_queue.sv =====
// Lexer back end: queue draining one token per cycle to the output register unless stalled.
`default_nettype none

module cll_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cll_pkg::push_t push_i,
  output logic           busy_o,
  input  wire logic      out_stall,
  output logic           out_valid,
  output cll_pkg::token_t out_tok
);
  import cll_pkg::*;

  localparam int unsigned QIW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  token_t           q_r [QUEUE_DEPTH];
  logic [QIW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  token_t           out_tok_r;
  logic             load;

  assign load       = (count_r != '0) && (!out_valid_r || !out_stall);
  assign wr_ptr_p1  = wr_ptr_r + QIW'(1);
  assign busy_o     = count_r > QCW'(QUEUE_DEPTH - 2);
  assign wr_ptr_nxt = wr_ptr_r + QIW'(push_i.cnt);
  assign rd_ptr_nxt = load ? rd_ptr_r + QIW'(1) : rd_ptr_r;
  assign count_nxt  = count_r + QCW'(push_i.cnt) - QCW'(load);

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      q_r[wr_ptr_p1] <= push_i.tok1;
    end
    if (load) begin
      out_tok_r <= q_r[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;

endmodule

`default_nettype wire

// ===== rtl/c_like_lexer.sv =====
// Top level of the streaming lexer for C-like source text.
// The input channel takes one source byte per word; byte 0 ends the text.
// The output channel gives one token per word: type, start offset, length,
// and a flag on the last token caused by one input byte.
// A byte is accepted when in_valid is high and in_stall is low. A token
// leaves when out_valid is high and out_stall is low.
// The scanner classifies a byte in the cycle it is accepted and pushes up to
// two tokens into a four-word queue; the first token of a byte passes through
// the queue and the output register before it appears at the output.
// Throughput is one byte per cycle while in_stall is low. A byte that causes
// two tokens needs two output words; the queue absorbs that, and in_stall
// rises when fewer than two queue words are free.
// When the receiver stalls, the output word holds and the queue fills; the
// queue then stalls the input.
// Synchronous reset empties the queue, drops out_valid and returns the
// scanner to the state between tokens at offset zero.
`default_nettype none

`include "c_like_lexer_assert.svh"

module c_like_lexer #(
  parameter int unsigned MAX_TEXT_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_token_type,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic             out_last_of_run
);
  import cll_pkg::*;

  push_t  push;
  token_t out_tok;

  cll_front #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .push_o       (push)
  );

  cll_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .busy_o    (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_tok   (out_tok)
  );

  assign out_token_type   = out_tok.kind;
  assign out_token_start  = out_tok.start;
  assign out_token_length = out_tok.length;
  assign out_last_of_run  = out_tok.last;

  `CLL_ASSERT(a_push_on_accept, (push.cnt == 2'd0) || (in_valid && !in_stall), "tokens pushed without an accepted byte")
  `CLL_ASSERT(a_nul_emits, !(in_valid && !in_stall && in_text_byte == CH_NUL) || (push.cnt != 2'd0), "end of text gave no token")
  `CLL_ASSERT(a_end_is_last, !(out_valid && out_token_type == TOK_END) || out_last_of_run, "end token not last of its run")
  `CLL_ASSERT_NEXT(a_run_follows, out_valid && !out_stall && !out_last_of_run, out_valid, "second token of a run not ready")

endmodule

`default_nettype wire

// ===== tb/sv/c_like_lexer_tb.sv =====
// Self-checking testbench for c_like_lexer with a token predictor and random gaps.
`timescale 1ns / 1ps

module c_like_lexer_tb;
  import cll_pkg::*;

  localparam int GAP_ODDS     = 8;
  localparam int CALM_TAIL    = 200;
  localparam int HALF_RANDOM  = 680;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [2:0] {
    LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR, LX_STRING, LX_STRING_ESC, LX_IDENT
  } lex_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_text_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_token_type;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic        out_last_of_run;

  logic [7:0]  text_q[$];
  token_t      want_tokens[$];
  token_t      byte_tokens[$];

  lex_mode_t   lx_mode;
  logic [15:0] lx_pos;
  logic [15:0] lx_start;
  logic [15:0] lx_len;

  logic        in_taken;
  int          in_gap;
  int          out_gap;
  int          quiet_cycles;
  int unsigned cyc;
  int          errors;
  string       puncts = "():;*[]{}";

  c_like_lexer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_type   (out_token_type),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [3:0] single_kind(logic [7:0] c);
    logic [3:0] k;
    case (c)
      "(":     k = TOK_LPAREN;
      ")":     k = TOK_RPAREN;
      ":":     k = TOK_COLON;
      ";":     k = TOK_SEMI;
      "*":     k = TOK_STAR;
      "[":     k = TOK_LBRACKET;
      "]":     k = TOK_RBRACKET;
      "{":     k = TOK_LBRACE;
      "}":     k = TOK_RBRACE;
      default: k = TOK_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] grow(logic [15:0] v);
    return (v == LEN_MAX) ? v : v + 16'd1;
  endfunction

  function automatic bit gaps_on();
    return text_q.size() > CALM_TAIL && cyc[8:7] != 2'b11;
  endfunction

  task automatic add_token(logic [3:0] kind, logic [15:0] start, logic [15:0] len);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.last   = 1'b0;
    byte_tokens.push_back(t);
  endtask

  task automatic lex_fresh(logic [7:0] c);
    lx_mode = LX_IDLE;
    if (c == CH_NUL) begin
      add_token(TOK_END, lx_pos, 16'd1);
    end else if (c == CH_SLASH) begin
      lx_mode  = LX_SLASH;
      lx_start = lx_pos;
    end else if (c == CH_QUOTE) begin
      lx_mode  = LX_STRING;
      lx_start = lx_pos + 16'd1;
      lx_len   = 16'd0;
    end else if (is_letter(c)) begin
      lx_mode  = LX_IDENT;
      lx_start = lx_pos;
      lx_len   = 16'd1;
    end else if (!is_blank(c)) begin
      add_token(single_kind(c), lx_pos, 16'd1);
    end
  endtask

  task automatic lex_byte(logic [7:0] c);
    token_t t;
    byte_tokens.delete();
    case (lx_mode)
      LX_SLASH: begin
        if (c == CH_SLASH) begin
          lx_mode = LX_LINE;
        end else if (c == CH_STAR) begin
          lx_mode = LX_BLOCK;
        end else begin
          add_token(TOK_UNKNOWN, lx_start, 16'd1);
          lex_fresh(c);
        end
      end
      LX_LINE: begin
        if (c == CH_NUL) begin
          lex_fresh(c);
        end else if (c == CH_LF || c == CH_CR) begin
          lx_mode = LX_IDLE;
        end
      end
      LX_BLOCK, LX_BLOCK_STAR: begin
        if (c == CH_NUL) begin
          lex_fresh(c);
        end else if (lx_mode == LX_BLOCK_STAR && c == CH_SLASH) begin
          lx_mode = LX_IDLE;
        end else begin
          lx_mode = (c == CH_STAR) ? LX_BLOCK_STAR : LX_BLOCK;
        end
      end
      LX_STRING: begin
        if (c == CH_NUL) begin
          add_token(TOK_STRING, lx_start, lx_len);
          lex_fresh(c);
        end else if (c == CH_QUOTE) begin
          add_token(TOK_STRING, lx_start, lx_len);
          lx_mode = LX_IDLE;
        end else begin
          lx_len = grow(lx_len);
          if (c == CH_BACKSLASH) begin
            lx_mode = LX_STRING_ESC;
          end
        end
      end
      LX_STRING_ESC: begin
        if (c == CH_NUL) begin
          add_token(TOK_STRING, lx_start, lx_len);
          lex_fresh(c);
        end else begin
          lx_len  = grow(lx_len);
          lx_mode = LX_STRING;
        end
      end
      LX_IDENT: begin
        if (is_letter(c) || is_numeral(c) || c == CH_UNDERLINE) begin
          lx_len = grow(lx_len);
        end else begin
          add_token(TOK_IDENT, lx_start, lx_len);
          lex_fresh(c);
        end
      end
      default: lex_fresh(c);
    endcase
    if (c == CH_NUL) begin
      lx_mode  = LX_IDLE;
      lx_pos   = 16'd0;
      lx_start = 16'd0;
      lx_len   = 16'd0;
    end else begin
      lx_pos = lx_pos + 16'd1;
    end
    if (byte_tokens.size() > 0) begin
      t = byte_tokens.pop_back();
      t.last = 1'b1;
      byte_tokens.push_back(t);
    end
    foreach (byte_tokens[i]) want_tokens.push_back(byte_tokens[i]);
  endtask

  task automatic put_text(string s);
    foreach (s[i]) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] any_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BACKSLASH);
    return b;
  endfunction

  task automatic put_string_body(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        text_q.push_back(CH_BACKSLASH);
        text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        text_q.push_back(plain_byte());
      end
    end
  endtask

  task automatic put_comment_body(int n, bit one_line);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: b = CH_STAR;
        1: b = " ";
        2: b = 8'($urandom_range(1, 255));
        default: b = any_letter();
      endcase
      if (one_line && (b == CH_LF || b == CH_CR)) b = "x";
      text_q.push_back(b);
    end
  endtask

  task automatic put_fragment();
    int n;
    case ($urandom_range(0, 11))
      0, 9: begin
        text_q.push_back(any_letter());
        n = $urandom_range(0, 7);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: text_q.push_back(8'($urandom_range(48, 57)));
            1: text_q.push_back(CH_UNDERLINE);
            default: text_q.push_back(any_letter());
          endcase
        end
      end
      1, 10: text_q.push_back(puncts[$urandom_range(0, 8)]);
      2, 11: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          text_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
        end
      end
      3: begin
        text_q.push_back(CH_QUOTE);
        put_string_body($urandom_range(0, 8));
        text_q.push_back(CH_QUOTE);
      end
      4: begin
        put_text("//");
        put_comment_body($urandom_range(0, 10), 1'b1);
        text_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
      end
      5: begin
        put_text("/*");
        put_comment_body($urandom_range(0, 10), 1'b0);
        put_text("*/");
      end
      6: text_q.push_back(CH_SLASH);
      7: begin
        case ($urandom_range(0, 2))
          0: text_q.push_back(8'($urandom_range(48, 57)));
          1: text_q.push_back(8'($urandom_range(128, 255)));
          default: text_q.push_back("#");
        endcase
      end
      default: text_q.push_back(8'($urandom_range(1, 255)));
    endcase
  endtask

  task automatic put_source_text();
    int n;
    n = $urandom_range(3, 30);
    for (int i = 0; i < n; i++) put_fragment();
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          text_q.push_back(CH_QUOTE);
          put_string_body($urandom_range(0, 4));
          if ($urandom_range(0, 1)) text_q.push_back(CH_BACKSLASH);
        end
        1: begin
          put_text("/*");
          put_comment_body($urandom_range(0, 4), 1'b0);
        end
        2: begin
          put_text("//");
          put_comment_body($urandom_range(0, 4), 1'b1);
        end
        default: text_q.push_back(CH_SLASH);
      endcase
    end
    text_q.push_back(CH_NUL);
  endtask

  initial begin
    int mark;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_text_byte = 8'h00;
    out_stall    = 1'b0;
    errors       = 0;
    lx_mode      = LX_IDLE;
    lx_pos       = 16'd0;
    lx_start     = 16'd0;
    lx_len       = 16'd0;

    put_text("():;*[]{}a_9(/;/*/*/");
    text_q.push_back(8'hFF);
    put_text("\"\\\"");
    text_q.push_back(CH_NUL);
    put_text("/*");
    text_q.push_back(CH_NUL);

    mark = text_q.size();
    while (text_q.size() < mark + HALF_RANDOM) put_source_text();
    mark = text_q.size();
    while (text_q.size() < mark + HALF_RANDOM) put_source_text();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_valid || want_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        in_gap = in_gap;
      end else if (in_gap != 0) begin
        in_gap   = in_gap - 1;
        in_valid <= 1'b0;
      end else if (text_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gaps_on() && $urandom_range(0, GAP_ODDS - 1) == 0) begin
        in_gap   = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else begin
        in_text_byte <= text_q.pop_front();
        in_valid     <= 1'b1;
      end

      if (out_gap != 0) begin
        out_gap   = out_gap - 1;
        out_stall <= 1'b1;
      end else if (gaps_on() && $urandom_range(0, GAP_ODDS - 1) == 0) begin
        out_gap   = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    token_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      cyc = cyc + 1;
      quiet_cycles = quiet_cycles + 1;
      if (in_valid && !in_stall) begin
        lex_byte(in_text_byte);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (want_tokens.size() == 0) begin
          errors = errors + 1;
          $display("%0t: expected no token, got type %0d start %0d length %0d last %0d",
                   $time, out_token_type, out_token_start, out_token_length,
                   out_last_of_run);
        end else begin
          want = want_tokens.pop_front();
          if (out_token_type !== want.kind || out_token_start !== want.start ||
              out_token_length !== want.length || out_last_of_run !== want.last) begin
            errors = errors + 1;
            $display("%0t: expected type %0d start %0d length %0d last %0d, got %0d %0d %0d %0d",
                     $time, want.kind, want.start, want.length, want.last,
                     out_token_type, out_token_start, out_token_length, out_last_of_run);
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    in_taken     = 1'b0;
    in_gap       = 0;
    out_gap      = 0;
    quiet_cycles = 0;
    cyc          = 0;
  end

endmodule
